// ===== src/ptcb_pkg.sv =====
package ptcb_pkg;

  // Default sizing of the bank
  localparam int unsigned NumChannelsDef = 16;
  localparam int unsigned CountWidthDef  = 32;

  // Input mode codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_ALLOC   = 3'd1;
  localparam logic [2:0] MODE_ENABLE  = 3'd2;
  localparam logic [2:0] MODE_DISABLE = 3'd3;
  localparam logic [2:0] MODE_UPDATE  = 3'd4;

  // Result event kinds
  localparam logic [1:0] EV_EXPIRED = 2'd0;
  localparam logic [1:0] EV_ALLOC   = 2'd1;
  localparam logic [1:0] EV_FAIL    = 2'd2;

  // Commands handed from the front to the back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ALLOC,
    OP_ENABLE,
    OP_DISABLE,
    OP_UPDATE
  } op_e;

  // One result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic       last;
  } res_t;

endpackage

// ===== src/ptcb_ram.sv =====
module ptcb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ptcb_front.sv =====
module ptcb_front
  import ptcb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef,
  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [2:0]             mode_i,
  input  logic [4:0]             channel_i,
  input  logic [31:0]            count_value_i,
  output logic                   cmd_vld_o,
  input  logic                   cmd_rdy_i,
  output op_e                    cmd_op_o,
  output logic [IdxW-1:0]        cmd_chan_o,
  output logic [COUNT_WIDTH-1:0] cmd_val_o
);

  localparam int unsigned QDepth = 2;

  logic                  keep;
  op_e                   op;
  logic                  in_range;
  logic [IdxW+4:0]       chan_ext;
  logic [COUNT_WIDTH+31:0] val_ext;
  logic                  accept;
  logic                  enq;
  logic                  deq;

  op_e                   op_q   [QDepth];
  logic [IdxW-1:0]       chan_q [QDepth];
  logic [COUNT_WIDTH-1:0] val_q [QDepth];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q, cnt_d;

  // Fit the input fields to the bank's widths
  assign in_range = (32'(channel_i) < NUM_CHANNELS);
  assign chan_ext = {{IdxW{1'b0}}, channel_i};
  assign val_ext  = {{COUNT_WIDTH{1'b0}}, count_value_i};

  // Classify the beat; drop what has no effect
  always_comb begin
    keep = 1'b0;
    op   = OP_TICK;
    unique case (mode_i)
      MODE_TICK: begin
        keep = 1'b1;
        op   = OP_TICK;
      end
      MODE_ALLOC: begin
        keep = 1'b1;
        op   = OP_ALLOC;
      end
      MODE_ENABLE: begin
        keep = in_range;
        op   = OP_ENABLE;
      end
      MODE_DISABLE: begin
        keep = in_range;
        op   = OP_DISABLE;
      end
      MODE_UPDATE: begin
        keep = in_range;
        op   = OP_UPDATE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign accept = push && !full;
  assign enq    = accept && keep;
  assign deq    = cmd_vld_o && cmd_rdy_i;

  // Hold the command queue
  always_ff @(posedge clk_i) begin
    if (enq) begin
      op_q[wr_ptr_q]   <= op;
      chan_q[wr_ptr_q] <= chan_ext[IdxW-1:0];
      val_q[wr_ptr_q]  <= val_ext[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({enq, deq})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  assign full       = (cnt_q == 2'(QDepth));
  assign cmd_vld_o  = (cnt_q != 2'd0);
  assign cmd_op_o   = op_q[rd_ptr_q];
  assign cmd_chan_o = chan_q[rd_ptr_q];
  assign cmd_val_o  = val_q[rd_ptr_q];

endmodule

// ===== src/ptcb_back.sv =====
module ptcb_back
  import ptcb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef,
  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_vld_i,
  output logic                   cmd_rdy_o,
  input  op_e                    cmd_op_i,
  input  logic [IdxW-1:0]        cmd_chan_i,
  input  logic [COUNT_WIDTH-1:0] cmd_val_i,
  input  logic                   pop,
  output logic                   empty,
  output res_t                   res_o
);

  localparam int unsigned AcW   = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned WordW = 2 * COUNT_WIDTH;
  localparam int unsigned RDepth = 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_CHANNELS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [NUM_CHANNELS-1:0] en_mask_q, en_mask_d;
  logic [NUM_CHANNELS-1:0] valid_q, valid_d;
  logic [AcW-1:0]          alloc_cnt_q, alloc_cnt_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;
  logic                    rd_valid_q;

  logic                    ram_we, ram_re;
  logic [IdxW-1:0]         ram_waddr, ram_raddr;
  logic [WordW-1:0]        ram_wdata, ram_rdata;

  logic [COUNT_WIDTH-1:0]  cur_cnt, cur_rel, dec;
  logic                    expire, stall;
  logic [IdxW-1:0]         alloc_idx;
  logic [IdxW+3:0]         pend_ext, alloc_ext;

  logic                    res_push, res_pop, res_full;
  res_t                    res_in;
  res_t                    res_q [RDepth];
  logic                    res_wr_q, res_rd_q;
  logic [1:0]              res_cnt_q, res_cnt_d;

  // Count and reload of each channel, reload in the upper half
  ptcb_ram #(
    .WIDTH (WordW),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A never-written channel reads as zero
  assign cur_cnt = rd_valid_q ? ram_rdata[COUNT_WIDTH-1:0] : '0;
  assign cur_rel = rd_valid_q ? ram_rdata[WordW-1:COUNT_WIDTH] : '0;
  assign dec     = cur_cnt - COUNT_WIDTH'(1);
  assign expire  = en_mask_q[idx_q] && (dec == '0);
  // An expiry must push the one before it; wait for room
  assign stall   = expire && pend_vld_q && res_full;

  assign alloc_idx = alloc_cnt_q[IdxW-1:0];
  assign pend_ext  = {4'b0, pend_idx_q};
  assign alloc_ext = {4'b0, alloc_idx};

  // Sequence the commands and the channel walk
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    en_mask_d   = en_mask_q;
    valid_d     = valid_q;
    alloc_cnt_d = alloc_cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    cmd_rdy_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {cur_rel, cur_rel};
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    res_push    = 1'b0;
    res_in      = '{kind: EV_EXPIRED, idx: pend_ext[3:0], last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          unique case (cmd_op_i)
            OP_TICK: begin
              cmd_rdy_o  = 1'b1;
              ram_re     = 1'b1;
              ram_raddr  = LastIdx;
              idx_d      = LastIdx;
              pend_vld_d = 1'b0;
              state_d    = ST_WALK;
            end
            OP_ALLOC: begin
              if (!res_full) begin
                cmd_rdy_o = 1'b1;
                res_push  = 1'b1;
                if (alloc_cnt_q < AcW'(NUM_CHANNELS)) begin
                  ram_we             = 1'b1;
                  ram_waddr          = alloc_idx;
                  ram_wdata          = {cmd_val_i, cmd_val_i};
                  valid_d[alloc_idx] = 1'b1;
                  alloc_cnt_d        = AcW'(alloc_cnt_q + 1'b1);
                  res_in = '{kind: EV_ALLOC, idx: alloc_ext[3:0], last: 1'b1};
                end else begin
                  res_in = '{kind: EV_FAIL, idx: 4'd0, last: 1'b1};
                end
              end
            end
            OP_ENABLE: begin
              cmd_rdy_o             = 1'b1;
              en_mask_d[cmd_chan_i] = 1'b1;
            end
            OP_DISABLE: begin
              cmd_rdy_o             = 1'b1;
              en_mask_d[cmd_chan_i] = 1'b0;
            end
            OP_UPDATE: begin
              cmd_rdy_o           = 1'b1;
              ram_we              = 1'b1;
              ram_waddr           = cmd_chan_i;
              ram_wdata           = {cmd_val_i, cmd_val_i};
              valid_d[cmd_chan_i] = 1'b1;
            end
            default: begin
              cmd_rdy_o = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!stall) begin
          // Write back the decremented or reloaded count
          if (en_mask_q[idx_q]) begin
            ram_we         = 1'b1;
            ram_wdata      = {cur_rel, expire ? cur_rel : dec};
            valid_d[idx_q] = 1'b1;
          end
          // Hold the newest expiry until the next one or the end shows it is last
          if (expire) begin
            res_push   = pend_vld_q;
            pend_vld_d = 1'b1;
            pend_idx_d = idx_q;
          end
          if (idx_q == '0) begin
            state_d = ST_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - IdxW'(1);
            idx_d     = idx_q - IdxW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (!res_full) begin
          res_push    = 1'b1;
          res_in.last = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      en_mask_q   <= '0;
      valid_q     <= '0;
      alloc_cnt_q <= '0;
      pend_vld_q  <= 1'b0;
      pend_idx_q  <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      en_mask_q   <= en_mask_d;
      valid_q     <= valid_d;
      alloc_cnt_q <= alloc_cnt_d;
      pend_vld_q  <= pend_vld_d;
      pend_idx_q  <= pend_idx_d;
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  // Result queue towards the consumer
  assign res_pop = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_in;
    end
  end

  always_comb begin
    res_cnt_d = res_cnt_q;
    case ({res_push, res_pop})
      2'b10:   res_cnt_d = res_cnt_q + 2'd1;
      2'b01:   res_cnt_d = res_cnt_q - 2'd1;
      default: res_cnt_d = res_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  assign res_full = (res_cnt_q == 2'(RDepth));
  assign empty    = (res_cnt_q == 2'd0);
  assign res_o    = res_q[res_rd_q];

endmodule

// ===== src/periodic_timer_channel_bank_top.sv =====
// Channel   Direction  Handshake          Beat
// command   in         push / full        mode_i, channel_i, count_value_i
// result    out        empty / pop        event_kind_o, channel_index_o, last_o
//
// A tick in the back end reads the last channel to start, walks down through
// every channel over the single read port of the count memory, then flushes.
// Allocate, enable, disable and update are handled in the idle state; a
// two-beat command queue lets the front accept while the back is busy.
// Reset clears all control state; per-channel valid bits make unwritten
// counts read as zero, so no clearing pass is needed.
// A full result queue stalls the walk at an expiry; the walk holds its place.
module periodic_timer_channel_bank_top
  import ptcb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [4:0]  channel_i,
  input  logic [31:0] count_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  channel_index_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                   cmd_vld, cmd_rdy;
  op_e                    cmd_op;
  logic [IdxW-1:0]        cmd_chan;
  logic [COUNT_WIDTH-1:0] cmd_val;
  res_t                   res;

  // Decode and queue commands
  ptcb_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .channel_i     (channel_i),
    .count_value_i (count_value_i),
    .cmd_vld_o     (cmd_vld),
    .cmd_rdy_i     (cmd_rdy),
    .cmd_op_o      (cmd_op),
    .cmd_chan_o    (cmd_chan),
    .cmd_val_o     (cmd_val)
  );

  // Carry out commands and walk the channels
  ptcb_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_vld),
    .cmd_rdy_o  (cmd_rdy),
    .cmd_op_i   (cmd_op),
    .cmd_chan_i (cmd_chan),
    .cmd_val_i  (cmd_val),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign event_kind_o    = res.kind;
  assign channel_index_o = res.idx;
  assign last_o          = res.last;

  // A failed allocation reports channel 0 and closes its item
  a_fail_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == EV_FAIL) |-> (channel_index_o == 4'd0 && last_o))
    else $error("allocation failure beat malformed");

  // An allocation gives exactly one result
  a_alloc_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == EV_ALLOC) |-> last_o)
    else $error("allocation beat not marked last");

  // A stalled command stays queued for the back end
  a_cmd_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_vld && !cmd_rdy) |=> (cmd_vld && $stable(cmd_op) && $stable(cmd_val)))
    else $error("command dropped while back end busy");

endmodule
